[design/lndw_pkg.sv]
// shared types and constants for the lcd nibble and decimal writer
// no dependencies; used by every module of the block
`timescale 1ns / 1ps
`default_nettype none

package lndw_pkg;

   localparam int MAX_DIGITS = 5;
   localparam int VALUE_W    = 16;
   localparam int BCD_W      = 4 * MAX_DIGITS;
   localparam int CONV_CNT_W = $clog2(VALUE_W);
   localparam int DIG_CNT_W  = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W     = $clog2(QUEUE_DEPTH);

   localparam logic [1:0] FUNC_CMD  = 2'd0;
   localparam logic [1:0] FUNC_CHAR = 2'd1;
   localparam logic [1:0] FUNC_NUM  = 2'd2;

   localparam logic RS_CMD  = 1'b0;
   localparam logic RS_DATA = 1'b1;

   localparam logic [7:0] ASCII_ZERO = 8'h30;

   function automatic logic [63:0] pow10(input int n);
      logic [63:0] p;
      p = 64'd1;
      for (int i = 0; i < n; i++) begin
         p = p * 64'd10;
      end
      return p;
   endfunction

   localparam logic [63:0] SAT_LIMIT = pow10(MAX_DIGITS) - 64'd1;

   typedef struct packed {
      logic       reg_select;
      logic [7:0] data;
      logic       last;
   } byte_job_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage

`default_nettype wire

[design/lndw_front.sv]
// front end: accepts items, converts numbers to decimal, queues byte jobs
// depends on lndw_pkg
`timescale 1ns / 1ps
`default_nettype none

module lndw_front (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_valid,
   output logic                            req_stall,
   input  wire logic [1:0]                 req_func,
   input  wire logic [lndw_pkg::VALUE_W-1:0] req_value,
   input  wire lndw_pkg::queue_status_type q_status,
   output logic                            q_push,
   output lndw_pkg::byte_job_type          q_job
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_PUSH_BYTE,
      ST_CONVERT,
      ST_EMIT
   } state_type;

   state_type                           state_ff;
   lndw_pkg::byte_job_type              job_ff;
   logic [lndw_pkg::VALUE_W-1:0]        bin_ff;
   logic [lndw_pkg::BCD_W-1:0]          bcd_ff;
   logic [lndw_pkg::CONV_CNT_W-1:0]     conv_cnt_ff;
   logic [lndw_pkg::DIG_CNT_W-1:0]      dig_cnt_ff;
   logic                                started_ff;

   logic                                accept;
   logic [lndw_pkg::VALUE_W-1:0]        sat_value;
   logic [lndw_pkg::BCD_W-1:0]          bcd_adj;
   logic [3:0]                          top_digit;
   logic                                need_emit;

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;

   always_comb begin
      if ({{(64-lndw_pkg::VALUE_W){1'b0}}, req_value} > lndw_pkg::SAT_LIMIT) begin
         sat_value = lndw_pkg::SAT_LIMIT[lndw_pkg::VALUE_W-1:0];
      end else begin
         sat_value = req_value;
      end
   end

   // add-3 correction on every digit before the shift
   always_comb begin
      for (int d = 0; d < lndw_pkg::MAX_DIGITS; d++) begin
         if (bcd_ff[4*d +: 4] >= 4'd5) begin
            bcd_adj[4*d +: 4] = bcd_ff[4*d +: 4] + 4'd3;
         end else begin
            bcd_adj[4*d +: 4] = bcd_ff[4*d +: 4];
         end
      end
   end

   assign top_digit = bcd_ff[lndw_pkg::BCD_W-1 -: 4];
   assign need_emit = (top_digit != 4'd0) || started_ff || (dig_cnt_ff == '0);

   always_comb begin
      q_push = 1'b0;
      q_job  = job_ff;
      unique case (state_ff)
         ST_PUSH_BYTE: begin
            q_push = !q_status.full;
         end
         ST_EMIT: begin
            q_push = need_emit && !q_status.full;
            q_job.reg_select = lndw_pkg::RS_DATA;
            q_job.data       = lndw_pkg::ASCII_ZERO | {4'd0, top_digit};
            q_job.last       = (dig_cnt_ff == '0);
         end
         default: begin
            q_push = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         started_ff <= 1'b0;
      end else begin
         unique case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  priority if (req_func == lndw_pkg::FUNC_CMD ||
                               req_func == lndw_pkg::FUNC_CHAR) begin
                     job_ff.reg_select <= (req_func == lndw_pkg::FUNC_CHAR) ?
                                          lndw_pkg::RS_DATA : lndw_pkg::RS_CMD;
                     job_ff.data       <= req_value[7:0];
                     job_ff.last       <= 1'b1;
                     state_ff          <= ST_PUSH_BYTE;
                  end else if (req_func == lndw_pkg::FUNC_NUM) begin
                     bin_ff      <= sat_value;
                     bcd_ff      <= '0;
                     conv_cnt_ff <= lndw_pkg::CONV_CNT_W'(lndw_pkg::VALUE_W - 1);
                     state_ff    <= ST_CONVERT;
                  end else begin
                     state_ff <= ST_IDLE;
                  end
               end
            end
            ST_PUSH_BYTE: begin
               if (!q_status.full) begin
                  state_ff <= ST_IDLE;
               end
            end
            ST_CONVERT: begin
               bcd_ff <= {bcd_adj[lndw_pkg::BCD_W-2:0], bin_ff[lndw_pkg::VALUE_W-1]};
               bin_ff <= {bin_ff[lndw_pkg::VALUE_W-2:0], 1'b0};
               if (conv_cnt_ff == '0) begin
                  dig_cnt_ff <= lndw_pkg::DIG_CNT_W'(lndw_pkg::MAX_DIGITS - 1);
                  started_ff <= 1'b0;
                  state_ff   <= ST_EMIT;
               end else begin
                  conv_cnt_ff <= conv_cnt_ff - 1'b1;
               end
            end
            ST_EMIT: begin
               if (!(need_emit && q_status.full)) begin
                  if (need_emit) begin
                     started_ff <= 1'b1;
                  end
                  bcd_ff <= {bcd_ff[lndw_pkg::BCD_W-5:0], 4'd0};
                  if (dig_cnt_ff == '0) begin
                     state_ff <= ST_IDLE;
                  end else begin
                     dig_cnt_ff <= dig_cnt_ff - 1'b1;
                  end
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   // the final digit of a number is never skipped
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT && dig_cnt_ff == '0 && !q_status.full) |-> q_push)
      else $error("final digit not queued");

endmodule

`default_nettype wire

[design/lndw_queue.sv]
// short fifo of byte jobs between front and back
// depends on lndw_pkg
`timescale 1ns / 1ps
`default_nettype none

module lndw_queue (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       push,
   input  wire lndw_pkg::byte_job_type     push_job,
   input  wire logic                       pop,
   output lndw_pkg::byte_job_type          head_job,
   output lndw_pkg::queue_status_type      status
);

   lndw_pkg::byte_job_type          mem_ff [lndw_pkg::QUEUE_DEPTH];
   logic [lndw_pkg::QPTR_W-1:0]     wr_ptr_ff;
   logic [lndw_pkg::QPTR_W-1:0]     rd_ptr_ff;
   logic [lndw_pkg::QPTR_W:0]       count_ff;

   assign status.full  = (count_ff == (lndw_pkg::QPTR_W+1)'(lndw_pkg::QUEUE_DEPTH));
   assign status.empty = (count_ff == '0);
   assign head_job     = mem_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         if (push && !pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

   assert property (@(posedge clock) disable iff (reset) push |-> !status.full)
      else $error("push into full queue");

   assert property (@(posedge clock) disable iff (reset) pop |-> !status.empty)
      else $error("pop from empty queue");

   assert property (@(posedge clock) disable iff (reset)
      count_ff <= (lndw_pkg::QPTR_W+1)'(lndw_pkg::QUEUE_DEPTH))
      else $error("queue count overflow");

endmodule

`default_nettype wire

[design/lndw_back.sv]
// back end: splits each queued byte into two nibble beats, high first
// depends on lndw_pkg
`timescale 1ns / 1ps
`default_nettype none

module lndw_back (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire lndw_pkg::queue_status_type q_status,
   input  wire lndw_pkg::byte_job_type     q_head,
   output logic                            q_pop,
   output logic                            rsp_valid,
   input  wire logic                       rsp_stall,
   output logic                            rsp_reg_select,
   output logic [3:0]                      rsp_nibble,
   output logic                            rsp_last_nibble
);

   logic                    rsp_valid_ff;
   logic                    rsp_reg_select_ff;
   logic [3:0]              rsp_nibble_ff;
   logic                    rsp_last_ff;
   logic                    low_pending_ff;
   lndw_pkg::byte_job_type  cur_ff;
   logic                    out_free;

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign q_pop    = out_free && !low_pending_ff && !q_status.empty;

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_reg_select  = rsp_reg_select_ff;
   assign rsp_nibble      = rsp_nibble_ff;
   assign rsp_last_nibble = rsp_last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff   <= 1'b0;
         low_pending_ff <= 1'b0;
      end else if (out_free) begin
         if (low_pending_ff) begin
            rsp_valid_ff      <= 1'b1;
            rsp_reg_select_ff <= cur_ff.reg_select;
            rsp_nibble_ff     <= cur_ff.data[3:0];
            rsp_last_ff       <= cur_ff.last;
            low_pending_ff    <= 1'b0;
         end else if (!q_status.empty) begin
            rsp_valid_ff      <= 1'b1;
            rsp_reg_select_ff <= q_head.reg_select;
            rsp_nibble_ff     <= q_head.data[7:4];
            rsp_last_ff       <= 1'b0;
            cur_ff            <= q_head;
            low_pending_ff    <= 1'b1;
         end else begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // a high nibble beat never carries the last flag
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && low_pending_ff) |-> !rsp_last_ff)
      else $error("last flag on high nibble");

endmodule

`default_nettype wire

[design/lcd_nibble_and_decimal_writer.sv]
// top level: 4-bit display writer for command, character and decimal items
// path: a byte item goes through the front job register, the queue and the back-end
// output register; a number first runs the one-bit-per-cycle binary to decimal shift
// loop in the front end, then queues its digits; requests stall until the item is queued
// back end sends one nibble beat per cycle while not stalled; synchronous reset empties
// queue and outputs; depends on lndw_pkg, lndw_front, lndw_queue, lndw_back
`timescale 1ns / 1ps
`default_nettype none

module lcd_nibble_and_decimal_writer (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_valid,
   output logic                              req_stall,
   input  wire logic [1:0]                   req_func,
   input  wire logic [lndw_pkg::VALUE_W-1:0] req_value,
   output logic                              rsp_valid,
   input  wire logic                         rsp_stall,
   output logic                              rsp_reg_select,
   output logic [3:0]                        rsp_nibble,
   output logic                              rsp_last_nibble
);

   lndw_pkg::queue_status_type q_status;
   lndw_pkg::byte_job_type     push_job;
   lndw_pkg::byte_job_type     head_job;
   logic                       q_push;
   logic                       q_pop;

   lndw_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_func  (req_func),
      .req_value (req_value),
      .q_status  (q_status),
      .q_push    (q_push),
      .q_job     (push_job)
   );

   lndw_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_job (push_job),
      .pop      (q_pop),
      .head_job (head_job),
      .status   (q_status)
   );

   lndw_back u_back (
      .clock           (clock),
      .reset           (reset),
      .q_status        (q_status),
      .q_head          (head_job),
      .q_pop           (q_pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_reg_select  (rsp_reg_select),
      .rsp_nibble      (rsp_nibble),
      .rsp_last_nibble (rsp_last_nibble)
   );

endmodule

`default_nettype wire

[sim/tb_top.sv]
// testbench for lcd_nibble_and_decimal_writer: command, character and decimal items
// an in-bench predictor queues the expected nibble beats; random idling and back pressure
// depends on lndw_pkg and the lcd_nibble_and_decimal_writer rtl
`timescale 1ns / 1ps

module tb_top;

   localparam logic [1:0] FUNC_UNUSED = 2'd3;
   localparam int CYCLE_LIMIT = 200000;
   localparam int DRAIN_TAIL  = 2 * (lndw_pkg::VALUE_W + lndw_pkg::MAX_DIGITS + 4);
   localparam int IDLE_PCT    = 31;

   typedef struct packed {
      logic       reg_select;
      logic [3:0] nibble;
      logic       last_nibble;
   } nibble_beat_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [1:0] req_func = 2'd0;
   logic [lndw_pkg::VALUE_W-1:0] req_value = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic rsp_reg_select;
   logic [3:0] rsp_nibble;
   logic rsp_last_nibble;

   nibble_beat_type pending_nibbles[$];
   int mismatch_count = 0;
   int cycle_count = 0;
   int hold_left = 0;
   bit req_idle_on = 1'b1;
   bit rsp_idle_on = 1'b1;

   lcd_nibble_and_decimal_writer dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_func        (req_func),
      .req_value       (req_value),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_reg_select  (rsp_reg_select),
      .rsp_nibble      (rsp_nibble),
      .rsp_last_nibble (rsp_last_nibble)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb_top failed");
         $finish;
      end
   end

   task automatic report_mismatch(input string what);
      $display("mismatch at %0t: %s", $realtime, what);
      mismatch_count++;
   endtask

   function automatic void push_byte(input logic rs, input logic [7:0] data, input logic fin);
      pending_nibbles.push_back('{reg_select: rs, nibble: data[7:4], last_nibble: 1'b0});
      pending_nibbles.push_back('{reg_select: rs, nibble: data[3:0], last_nibble: fin});
   endfunction

   function automatic void predict_transfers(input logic [1:0] f,
                                             input logic [lndw_pkg::VALUE_W-1:0] v);
      logic [7:0] digit_chars [lndw_pkg::MAX_DIGITS];
      logic [63:0] num;
      int count;
      count = 0;
      if (f == lndw_pkg::FUNC_CMD) begin
         push_byte(lndw_pkg::RS_CMD, v[7:0], 1'b1);
      end else if (f == lndw_pkg::FUNC_CHAR) begin
         push_byte(lndw_pkg::RS_DATA, v[7:0], 1'b1);
      end else if (f == lndw_pkg::FUNC_NUM) begin
         num = 64'(v);
         if (num > lndw_pkg::SAT_LIMIT) num = lndw_pkg::SAT_LIMIT;
         if (num == 64'd0) begin
            digit_chars[0] = lndw_pkg::ASCII_ZERO;
            count = 1;
         end else begin
            while (num != 64'd0 && count < lndw_pkg::MAX_DIGITS) begin
               digit_chars[count] = lndw_pkg::ASCII_ZERO + 8'(num % 64'd10);
               num = num / 64'd10;
               count++;
            end
         end
         for (int i = count - 1; i >= 0; i--) begin
            push_byte(lndw_pkg::RS_DATA, digit_chars[i], i == 0);
         end
      end
   endfunction

   // receiver side: a pending long hold takes priority, otherwise random stalls when enabled
   always @(negedge clock) begin
      if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else if (rsp_idle_on && $urandom_range(99) < IDLE_PCT) begin
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   always @(posedge clock) begin
      nibble_beat_type exp_beat;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_nibbles.size() == 0) begin
            report_mismatch($sformatf("unexpected beat rs=%0b nibble=%h last=%0b",
                                      rsp_reg_select, rsp_nibble, rsp_last_nibble));
         end else begin
            exp_beat = pending_nibbles.pop_front();
            if (rsp_reg_select !== exp_beat.reg_select)
               report_mismatch($sformatf("reg_select %0b, expected %0b",
                                         rsp_reg_select, exp_beat.reg_select));
            if (rsp_nibble !== exp_beat.nibble)
               report_mismatch($sformatf("nibble %h, expected %h",
                                         rsp_nibble, exp_beat.nibble));
            if (rsp_last_nibble !== exp_beat.last_nibble)
               report_mismatch($sformatf("last_nibble %0b, expected %0b",
                                         rsp_last_nibble, exp_beat.last_nibble));
         end
      end
   end

   task automatic send_item(input logic [1:0] f, input logic [lndw_pkg::VALUE_W-1:0] v);
      @(negedge clock);
      while (req_idle_on && $urandom_range(99) < IDLE_PCT) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid = 1'b1;
      req_func  = f;
      req_value = v;
      do @(posedge clock); while (req_stall);
      predict_transfers(f, v);
   endtask

   task automatic wait_drained();
      @(negedge clock);
      req_valid = 1'b0;
      while (pending_nibbles.size() != 0) @(posedge clock);
      repeat (DRAIN_TAIL) @(posedge clock);
   endtask

   function automatic logic [lndw_pkg::VALUE_W-1:0] random_number();
      case ($urandom_range(5))
         0: return lndw_pkg::VALUE_W'($urandom_range(9));
         1: return lndw_pkg::VALUE_W'($urandom_range(99, 10));
         2: return lndw_pkg::VALUE_W'($urandom_range(999, 100));
         3: return lndw_pkg::VALUE_W'($urandom_range(9999, 1000));
         4: return lndw_pkg::VALUE_W'($urandom_range(65535, 10000));
         default: return lndw_pkg::VALUE_W'($urandom());
      endcase
   endfunction

   task automatic test_bytes();
      logic [lndw_pkg::VALUE_W-1:0] byte_vals [6] = '{16'h0000, 16'h00FF, 16'hFF00,
                                                     16'hFFFF, 16'h5AA5, 16'hA55A};
      foreach (byte_vals[i]) begin
         send_item(lndw_pkg::FUNC_CMD, byte_vals[i]);
         send_item(lndw_pkg::FUNC_CHAR, byte_vals[i]);
      end
   endtask

   task automatic test_numbers();
      logic [lndw_pkg::VALUE_W-1:0] num_vals [10] = '{16'd0, 16'd1, 16'd9, 16'd10, 16'd99,
                                                     16'd100, 16'd10000, 16'd12345,
                                                     16'd60000, 16'd65535};
      foreach (num_vals[i]) send_item(lndw_pkg::FUNC_NUM, num_vals[i]);
   endtask

   task automatic test_unused_func();
      send_item(FUNC_UNUSED, 16'h0000);
      send_item(FUNC_UNUSED, 16'hFFFF);
      send_item(lndw_pkg::FUNC_CHAR, 16'h0041);
      send_item(FUNC_UNUSED, 16'(($urandom())));
      send_item(lndw_pkg::FUNC_NUM, 16'd7);
   endtask

   task automatic test_back_pressure();
      @(posedge clock);
      hold_left = 300;
      for (int i = 0; i < 40; i++) begin
         if (i % 4 == 3) send_item(lndw_pkg::FUNC_CMD, 16'($urandom()));
         else send_item(lndw_pkg::FUNC_NUM, random_number());
      end
   endtask

   task automatic test_random();
      int accepted;
      int pick;
      accepted = 0;
      while (accepted < 180) begin
         req_idle_on = !(accepted >= 60 && accepted < 120);
         rsp_idle_on = req_idle_on;
         pick = $urandom_range(99);
         if (pick < 5) begin
            send_item(FUNC_UNUSED, 16'($urandom()));
         end else begin
            if (pick < 30) send_item(lndw_pkg::FUNC_CMD, 16'($urandom()));
            else if (pick < 55) send_item(lndw_pkg::FUNC_CHAR, 16'($urandom()));
            else send_item(lndw_pkg::FUNC_NUM, random_number());
            accepted++;
         end
         if (accepted % 80 == 79 && pick >= 5) wait_drained();
      end
      req_idle_on = 1'b1;
      rsp_idle_on = 1'b1;
   endtask

   initial begin
      repeat (6) @(negedge clock);
      reset = 1'b0;
      test_bytes();
      test_numbers();
      test_unused_func();
      wait_drained();
      test_back_pressure();
      wait_drained();
      test_random();
      wait_drained();
      if (mismatch_count == 0) begin
         $display("tb_top passed");
      end else begin
         $display("tb_top failed");
      end
      $finish;
   end

endmodule
